/* hdl/rtte_pkg.sv */
// ---------------------------------------------------------------------------
// rtte_pkg
// shared widths, constants and types of the rtt threshold estimator
// ---------------------------------------------------------------------------
package rtte_pkg;

  localparam int SAMPLE_W = 26;
  localparam int SEQ_W    = 32;
  localparam int EST_W    = 32;
  localparam int THR_W    = 31;
  localparam int RTOMIN_W = 24;

  // a zero sample is taken as one millisecond by the estimator
  localparam logic [SAMPLE_W-1:0] ZERO_SAMPLE_US   = SAMPLE_W'(1000);
  localparam logic [RTOMIN_W-1:0] RTO_MIN_RESET    = RTOMIN_W'(200000);
  localparam logic                FORCE_CONG_RESET = 1'b1;

  typedef enum logic {
    CFG_RTO_MIN    = 1'b0,
    CFG_FORCE_CONG = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [EST_W-1:0] srtt_x8;
    logic [EST_W-1:0] mdev_x4;
    logic [EST_W-1:0] dev_peak;
    logic [EST_W-1:0] rtt_var;
    logic [SEQ_W-1:0] seq_mark;
  } est_state_t;

endpackage

/* hdl/rtte_update.sv */
// ---------------------------------------------------------------------------
// rtte_update
// next estimator state for one sample: first-sample init, smoothed rtt and
// mean deviation update, deviation peak tracking and per-window decay
// ---------------------------------------------------------------------------
module rtte_update (
  input  rtte_pkg::est_state_t              cur,
  input  logic [rtte_pkg::SAMPLE_W-1:0]     meas,
  input  logic [rtte_pkg::SEQ_W-1:0]        unacked_seq,
  input  logic [rtte_pkg::SEQ_W-1:0]        next_seq,
  input  logic [rtte_pkg::RTOMIN_W-1:0]     rto_min,
  output rtte_pkg::est_state_t              nxt
);
  import rtte_pkg::*;

  logic               first;
  logic signed [33:0] err;
  logic signed [33:0] neg_err;
  logic signed [33:0] mdev_q4;
  logic signed [33:0] adj_neg;
  logic signed [33:0] adj;
  logic        [33:0] srtt_sum;
  logic signed [34:0] mdev_sum;
  logic [EST_W-1:0]   mdev_new;
  logic [EST_W-1:0]   peak1;
  logic [EST_W-1:0]   var1;
  logic [EST_W-1:0]   init_mdev;
  logic [EST_W-1:0]   rto_min_w;
  logic [SEQ_W-1:0]   seq_diff;
  logic               win_passed;

  always_comb begin
    first     = (cur.srtt_x8 == '0);
    rto_min_w = {{(EST_W-RTOMIN_W){1'b0}}, rto_min};

    // error against srtt/8, signed
    err     = $signed({8'b0, meas}) - $signed({5'b0, cur.srtt_x8[31:3]});
    neg_err = -err;
    mdev_q4 = $signed({4'b0, cur.mdev_x4[31:2]});
    adj_neg = neg_err - mdev_q4;
    if (err[33]) begin
      // negative error: positive correction cut by a further eighth
      adj = adj_neg[33] || (adj_neg == '0) ? adj_neg : (adj_neg >>> 3);
    end else begin
      adj = err - mdev_q4;
    end

    srtt_sum = {2'b0, cur.srtt_x8} + $unsigned(err);
    mdev_sum = $signed({3'b0, cur.mdev_x4}) + $signed({adj[33], adj});
    mdev_new = mdev_sum[34] ? '0 : mdev_sum[31:0];

    if (mdev_new > cur.dev_peak) begin
      peak1 = mdev_new;
      var1  = (mdev_new > cur.rtt_var) ? mdev_new : cur.rtt_var;
    end else begin
      peak1 = cur.dev_peak;
      var1  = cur.rtt_var;
    end

    seq_diff   = cur.seq_mark - unacked_seq;
    win_passed = seq_diff[SEQ_W-1];

    init_mdev = {5'b0, meas, 1'b0};

    nxt = cur;
    if (first) begin
      nxt.srtt_x8  = {3'b0, meas, 3'b0};
      nxt.mdev_x4  = init_mdev;
      nxt.dev_peak = (init_mdev > rto_min_w) ? init_mdev : rto_min_w;
      nxt.rtt_var  = (init_mdev > rto_min_w) ? init_mdev : rto_min_w;
      nxt.seq_mark = next_seq;
    end else begin
      nxt.srtt_x8  = srtt_sum[31:0];
      nxt.mdev_x4  = mdev_new;
      nxt.dev_peak = peak1;
      nxt.rtt_var  = var1;
      if (win_passed) begin
        // variance decays by a quarter of the gap to the peak
        if (peak1 < var1) begin
          nxt.rtt_var = var1 - ((var1 - peak1) >> 2);
        end
        nxt.seq_mark = next_seq;
        nxt.dev_peak = rto_min_w;
      end
    end
  end

endmodule

/* hdl/rtt_threshold_estimator.sv */
// ---------------------------------------------------------------------------
// rtt_threshold_estimator
// rtt estimator with deviation tracking, rto, threshold and congestion flag
// ---------------------------------------------------------------------------
// throughput: one item per cycle unless out_stall holds it back; estimator
//   state updates as an item leaves the input register, back to back
// reset (rst, synchronous): estimator state, previous sample and all valid
//   bits cleared; rto_min back to 200000 us, force_congested back to 1
// ---------------------------------------------------------------------------
module rtt_threshold_estimator (
  input  logic                              clk,
  input  logic                              rst,
  // sample channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [rtte_pkg::SAMPLE_W-1:0]     rtt_sample,
  input  logic [rtte_pkg::SEQ_W-1:0]        unacked_seq,
  input  logic [rtte_pkg::SEQ_W-1:0]        next_seq,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [rtte_pkg::EST_W-1:0]        rto,
  output logic [rtte_pkg::THR_W-1:0]        rtt_threshold,
  output logic                              congested,
  // configuration write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  rtte_pkg::cfg_reg_e                cfg_index,
  input  logic [rtte_pkg::RTOMIN_W-1:0]     cfg_data
);
  import rtte_pkg::*;

  // configuration registers
  logic [RTOMIN_W-1:0] rto_min;
  logic                force_congested;

  // stage 1: input register
  logic                s1_valid;
  logic [SAMPLE_W-1:0] s1_sample;
  logic [SEQ_W-1:0]    s1_una;
  logic [SEQ_W-1:0]    s1_nxt;

  // stage 2: estimator state; while s2_valid it belongs to the stage 2 item
  logic                s2_valid;
  est_state_t          est;
  est_state_t          est_next;
  logic [SAMPLE_W-1:0] s2_sample;  // doubles as the previous sample
  logic [SAMPLE_W-1:0] s2_prev;
  logic [SAMPLE_W-1:0] s1_meas;

  // stage 3: rto
  logic                s3_valid;
  logic [EST_W-1:0]    s3_rto;
  logic [SAMPLE_W-1:0] s3_sample;
  logic [SAMPLE_W-1:0] s3_prev;

  // handshake
  logic ready4, ready3, ready2, ready1;
  logic adv4, adv3, adv2, in_acc;

  // congestion test
  logic [THR_W-1:0]      thr;
  logic [SAMPLE_W+1:0]   sample_x3;
  logic                  rule_trend;
  logic                  rule_over;
  logic                  cong_next;

  // a stage moves on when the one after it is empty or moving too
  always_comb begin
    ready4   = !out_valid || !out_stall;
    adv4     = s3_valid && ready4;
    ready3   = !s3_valid || ready4;
    adv3     = s2_valid && ready3;
    ready2   = !s2_valid || ready3;
    adv2     = s1_valid && ready2;
    ready1   = !s1_valid || ready2;
    in_stall = !ready1;
    in_acc   = in_valid && ready1;
  end

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rto_min         <= RTO_MIN_RESET;
      force_congested <= FORCE_CONG_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_RTO_MIN:    rto_min         <= cfg_data;
        CFG_FORCE_CONG: force_congested <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // stage 1
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_acc) begin
      s1_valid <= 1'b1;
    end else if (adv2) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_sample <= rtt_sample;
      s1_una    <= unacked_seq;
      s1_nxt    <= next_seq;
    end
  end

  // zero sample counts as the default
  assign s1_meas = (s1_sample == '0) ? ZERO_SAMPLE_US : s1_sample;

  rtte_update u_update (
    .cur         (est),
    .meas        (s1_meas),
    .unacked_seq (s1_una),
    .next_seq    (s1_nxt),
    .rto_min     (rto_min),
    .nxt         (est_next)
  );

  // stage 2: state update
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid  <= 1'b0;
      est       <= '0;
      s2_sample <= '0;
    end else begin
      if (adv2) begin
        s2_valid  <= 1'b1;
        est       <= est_next;
        s2_sample <= s1_sample;
      end else if (adv3) begin
        s2_valid  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      s2_prev <= s2_sample;
    end
  end

  // stage 3: rto from the item's own state
  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (adv3) begin
      s3_valid <= 1'b1;
    end else if (adv4) begin
      s3_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv3) begin
      s3_rto    <= {3'b0, est.srtt_x8[EST_W-1:3]} + est.rtt_var;
      s3_sample <= s2_sample;
      s3_prev   <= s2_prev;
    end
  end

  // sample > floor(2*thr/3) is the same test as 3*sample > 2*thr
  always_comb begin
    thr        = s3_rto[EST_W-1:1];
    sample_x3  = {1'b0, s3_sample, 1'b0} + {2'b0, s3_sample};
    rule_trend = ({{(EST_W-SAMPLE_W-2){1'b0}}, sample_x3} > {thr, 1'b0}) &&
                 (s3_sample > s3_prev) && (s3_prev != '0);
    rule_over  = {{(THR_W-SAMPLE_W){1'b0}}, s3_sample} > thr;
    cong_next  = force_congested || rule_trend || rule_over;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv4) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv4) begin
      rto           <= s3_rto;
      rtt_threshold <= thr;
      congested     <= cong_next;
    end
  end

  // the input side stalls only with a full input register
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid)
    else $error("input stalled with empty input register");

  // once a sample has gone through the update the estimate is never zero
  a_srtt_live: assert property (@(posedge clk) disable iff (rst)
    adv2 |=> (est.srtt_x8 != '0))
    else $error("smoothed rtt zero after an update");

  // a new result only comes from a filled rto stage
  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s3_valid))
    else $error("result without a source item");

  // an item leaving stage 1 always lands in stage 2
  a_s2_fill: assert property (@(posedge clk) disable iff (rst)
    adv2 |=> s2_valid)
    else $error("state stage lost an item");

endmodule

/* sim/rtte_checker.sv */
// ---------------------------------------------------------------------------
// rtte_checker
// watches the sample, result and configuration channels of the rtt threshold
// estimator, predicts each result and compares it field by field
// ---------------------------------------------------------------------------
module rtte_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [rtte_pkg::SAMPLE_W-1:0] rtt_sample,
  input  logic [rtte_pkg::SEQ_W-1:0]    unacked_seq,
  input  logic [rtte_pkg::SEQ_W-1:0]    next_seq,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [rtte_pkg::EST_W-1:0]    rto,
  input  logic [rtte_pkg::THR_W-1:0]    rtt_threshold,
  input  logic                          congested,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  rtte_pkg::cfg_reg_e            cfg_index,
  input  logic [rtte_pkg::RTOMIN_W-1:0] cfg_data,
  output int                            fail_count,
  output int                            pending_count
);
  import rtte_pkg::*;

  localparam int REPORT_CAP = 100;

  typedef struct packed {
    logic [EST_W-1:0] rto;
    logic [THR_W-1:0] thr;
    logic             cong;
  } rto_result_t;

  est_state_t          est;
  logic [SAMPLE_W-1:0] last_sample;
  logic [RTOMIN_W-1:0] rto_min_q;
  logic                force_cong_q;
  rto_result_t         rto_expected_q[$];
  rto_result_t         want;
  int                  fails;

  function automatic rto_result_t next_estimate(input logic [SAMPLE_W-1:0] sample,
                                                input logic [SEQ_W-1:0]    una,
                                                input logic [SEQ_W-1:0]    nxt);
    longint      m;
    longint      srtt;
    longint      mdev;
    longint      err;
    longint      adj;
    logic [31:0] gap;
    logic [63:0] rto64;
    logic [63:0] thr64;
    logic [63:0] smp;
    rto_result_t r;
    m = (sample == '0) ? 64'(ZERO_SAMPLE_US) : 64'(sample);
    if (est.srtt_x8 != '0) begin
      srtt = 64'(est.srtt_x8);
      mdev = 64'(est.mdev_x4);
      err  = m - (srtt >>> 3);
      srtt = srtt + err;
      if (err < 0) begin
        // negative error: a growing deviation is damped a further eighth
        adj = -err - (mdev >>> 2);
        if (adj > 0) adj = adj >>> 3;
      end else begin
        adj = err - (mdev >>> 2);
      end
      mdev = mdev + adj;
      if (mdev < 0) mdev = 0;
      est.srtt_x8 = srtt[31:0];
      est.mdev_x4 = mdev[31:0];
      if (est.mdev_x4 > est.dev_peak) begin
        est.dev_peak = est.mdev_x4;
        if (est.dev_peak > est.rtt_var) est.rtt_var = est.dev_peak;
      end
      gap = est.seq_mark - una;
      if (gap[31]) begin
        if (est.dev_peak < est.rtt_var)
          est.rtt_var = est.rtt_var - ((est.rtt_var - est.dev_peak) >> 2);
        est.seq_mark = nxt;
        est.dev_peak = 32'(rto_min_q);
      end
    end else begin
      // no estimate yet
      srtt = m <<< 3;
      mdev = m <<< 1;
      est.srtt_x8  = srtt[31:0];
      est.mdev_x4  = mdev[31:0];
      est.dev_peak = (est.mdev_x4 > 32'(rto_min_q)) ? est.mdev_x4 : 32'(rto_min_q);
      est.rtt_var  = est.dev_peak;
      est.seq_mark = nxt;
    end
    rto64 = 64'(est.srtt_x8 >> 3) + 64'(est.rtt_var);
    r.rto = rto64[31:0];
    thr64 = 64'(r.rto) >> 1;
    r.thr = thr64[30:0];
    if (!force_cong_q) begin
      smp    = 64'(sample);
      r.cong = ((smp > (thr64 * 2) / 3) && (sample > last_sample) && (last_sample != '0))
               || (smp > thr64);
    end else begin
      r.cong = 1'b1;
    end
    last_sample = sample;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      est          = '0;
      last_sample  = '0;
      rto_min_q    = RTO_MIN_RESET;
      force_cong_q = FORCE_CONG_RESET;
      rto_expected_q.delete();
      fails        = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_RTO_MIN) rto_min_q = cfg_data;
        else                          force_cong_q = cfg_data[0];
      end
      if (out_valid && !out_stall) begin
        if (rto_expected_q.size() == 0) begin
          fails++;
          if (fails <= REPORT_CAP) $error("result with no item waiting: rto %0d", rto);
        end else begin
          want = rto_expected_q.pop_front();
          if (rto !== want.rto) begin
            fails++;
            if (fails <= REPORT_CAP)
              $error("rto: expected %0d, actual %0d", want.rto, rto);
          end
          if (rtt_threshold !== want.thr) begin
            fails++;
            if (fails <= REPORT_CAP)
              $error("rtt_threshold: expected %0d, actual %0d", want.thr, rtt_threshold);
          end
          if (congested !== want.cong) begin
            fails++;
            if (fails <= REPORT_CAP)
              $error("congested: expected %0d, actual %0d", want.cong, congested);
          end
        end
      end
      if (in_valid && !in_stall)
        rto_expected_q.push_back(next_estimate(rtt_sample, unacked_seq, next_seq));
    end
    fail_count    <= fails;
    pending_count <= rto_expected_q.size();
  end

endmodule

/* sim/tb_rtt_threshold_estimator.sv */
// ---------------------------------------------------------------------------
// tb_rtt_threshold_estimator
// drives samples and register writes into the rtt threshold estimator, with
// random gaps and back-pressure; a checker beside the block predicts every
// result and the top reports the verdict
// ---------------------------------------------------------------------------
module tb_rtt_threshold_estimator;
  import rtte_pkg::*;

  // once the queue is empty a short tail is plenty
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int CHUNK_ITEMS  = 217;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  logic [SAMPLE_W-1:0] rtt_sample;
  logic [SEQ_W-1:0]    unacked_seq;
  logic [SEQ_W-1:0]    next_seq;
  logic                out_valid;
  logic                out_stall;
  logic [EST_W-1:0]    rto;
  logic [THR_W-1:0]    rtt_threshold;
  logic                congested;
  logic                cfg_valid;
  logic                cfg_ready;
  cfg_reg_e            cfg_index;
  logic [RTOMIN_W-1:0] cfg_data;

  int fail_count;
  int pending_count;
  int tx_idle_pct;
  int rx_idle_pct;
  int cycle_count;

  rtt_threshold_estimator i_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .rtt_sample    (rtt_sample),
    .unacked_seq   (unacked_seq),
    .next_seq      (next_seq),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .rto           (rto),
    .rtt_threshold (rtt_threshold),
    .congested     (congested),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  rtte_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .rtt_sample    (rtt_sample),
    .unacked_seq   (unacked_seq),
    .next_seq      (next_seq),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .rto           (rto),
    .rtt_threshold (rtt_threshold),
    .congested     (congested),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  // free-running clock, period 10
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // watchdog: a hung handshake ends the run here
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // receiver back-pressure, redrawn every cycle
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
    end
  end

  // one item on the sample channel; valid only drops when the sender idles,
  // so back-to-back items keep it high without a second assignment
  task automatic send_sample(input logic [SAMPLE_W-1:0] smp,
                             input logic [SEQ_W-1:0]    una,
                             input logic [SEQ_W-1:0]    nxt);
    int gap;
    if ($urandom_range(0, 99) < tx_idle_pct) begin
      gap = $urandom_range(1, 6);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid    <= 1'b1;
    rtt_sample  <= smp;
    unacked_seq <= una;
    next_seq    <= nxt;
    do @(posedge clk); while (in_stall);
  endtask

  // hold the sender off until every predicted result has come back
  task automatic quiesce();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input cfg_reg_e idx, input logic [RTOMIN_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [SEQ_W-1:0]    una_cur;
    logic [SEQ_W-1:0]    nxt_cur;
    logic [SAMPLE_W-1:0] smp;
    int                  base_rtt;
    int                  pick;
    int                  chunk;
    int                  n;

    rst         = 1'b1;
    in_valid    = 1'b0;
    rtt_sample  = '0;
    unacked_seq = '0;
    next_seq    = '0;
    out_stall   = 1'b0;
    cfg_valid   = 1'b0;
    cfg_index   = CFG_RTO_MIN;
    cfg_data    = '0;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    una_cur     = '0;
    nxt_cur     = '0;
    base_rtt    = 20000;

    repeat (12) @(negedge clk);
    rst <= 1'b0;
    repeat (2) @(negedge clk);

    // ---- directed part ----
    // reset settings: forced congestion, 200 ms floor
    // first sample is a zero one: initialises the estimate as 1000 us
    send_sample('0, 32'd0, 32'd100);
    // largest sample, strong positive error, mark not yet passed
    send_sample({SAMPLE_W{1'b1}}, 32'h0000_0000, 32'hFFFF_FFFF);

    quiesce();
    cfg_write(CFG_FORCE_CONG, '0);
    cfg_write(CFG_RTO_MIN, '0);
    // tiny samples: negative error with damped deviation, window passed
    send_sample(26'd1, 32'd101, 32'd5000);
    // unacked equal to the mark does not count as passed
    send_sample(26'd1, 32'd5000, 32'd6000);
    // rising sample with a non-zero previous one
    send_sample(26'd2, 32'd5000, 32'd6000);
    // zero sample: raw zero seen by the congestion rule
    send_sample('0, 32'd5000, 32'd7000);
    // zero previous sample blocks the two-thirds branch
    send_sample(26'd50000, 32'd5001, 32'hFFFF_FFFF);
    // sequence wrap: 0 is after 0xffffffff
    send_sample(26'd60000, 32'd0, 32'd100);
    // half-space distance counts as after
    send_sample(26'd55000, 32'h8000_0064, 32'h8000_1000);
    send_sample(26'd54000, 32'h8000_0064, 32'h8000_2000);

    quiesce();
    cfg_write(CFG_RTO_MIN, {RTOMIN_W{1'b1}});
    // deviation floor at its top: variance stays high, peak reset to it
    send_sample(26'd100000, 32'h8000_1001, 32'h8000_3000);
    send_sample(26'd140000, 32'h8000_1001, 32'h8000_3000);
    send_sample(26'd90000, 32'h8000_3001, 32'h8000_4000);
    send_sample({SAMPLE_W{1'b1}}, 32'hFFFF_FFFF, 32'h0000_0000);
    send_sample(26'd1, 32'h0000_0001, 32'h5555_5555);
    send_sample(26'h2AAAAAA, 32'hAAAA_AAAA, 32'hAAAA_AAAA);
    send_sample(26'h1555555, 32'h5555_5555, 32'h5555_5555);

    // ---- random part ----
    // six chunks, two per idling setting, each with its own register values
    una_cur = 32'hFFFF_0000;
    nxt_cur = una_cur + 32'd4000;
    for (chunk = 0; chunk < 6; chunk++) begin
      case (chunk / 2)
        0: begin
          tx_idle_pct = 26;
          rx_idle_pct = 59;
        end
        1: begin
          tx_idle_pct = 59;
          rx_idle_pct = 26;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      quiesce();
      case (chunk)
        0: begin
          cfg_write(CFG_FORCE_CONG, '0);
          cfg_write(CFG_RTO_MIN, RTOMIN_W'(200000));
        end
        1: begin
          cfg_write(CFG_RTO_MIN, '0);
        end
        2: begin
          cfg_write(CFG_FORCE_CONG, RTOMIN_W'(1));
          cfg_write(CFG_RTO_MIN, {RTOMIN_W{1'b1}});
        end
        3: begin
          cfg_write(CFG_FORCE_CONG, '0);
          cfg_write(CFG_RTO_MIN, RTOMIN_W'($urandom_range(0, 16777215)));
        end
        4: begin
          cfg_write(CFG_RTO_MIN, RTOMIN_W'(1000));
        end
        default: begin
          cfg_write(CFG_FORCE_CONG, RTOMIN_W'(1));
          cfg_write(CFG_RTO_MIN, RTOMIN_W'(50000));
        end
      endcase

      for (n = 0; n < CHUNK_ITEMS; n++) begin
        // now and then the path delay moves to a new level
        if ($urandom_range(0, 31) == 0) begin
          if ($urandom_range(0, 3) == 0) base_rtt = $urandom_range(8, 2000);
          else                           base_rtt = $urandom_range(2000, 2000000);
        end
        pick = $urandom_range(0, 99);
        // well-formed flow: unacked creeps forward, next leads it by a window
        una_cur = una_cur + 32'($urandom_range(0, 3000));
        nxt_cur = una_cur + 32'($urandom_range(1, 8000));
        smp = SAMPLE_W'(base_rtt + $urandom_range(0, base_rtt / 4) - base_rtt / 8);
        if (pick < 70) begin
          send_sample(smp, una_cur, nxt_cur);
        end else if (pick < 85) begin
          send_sample(SAMPLE_W'($urandom_range(0, 67108863)), una_cur, nxt_cur);
        end else if (pick < 92) begin
          case ($urandom_range(0, 2))
            0:       smp = '0;
            1:       smp = {SAMPLE_W{1'b1}};
            default: smp = SAMPLE_W'(1);
          endcase
          send_sample(smp, una_cur, nxt_cur);
        end else begin
          // noise on the sequence numbers
          send_sample(smp, $urandom, $urandom);
        end
        // occasional full pause with the pipeline drained
        if ($urandom_range(0, 99) == 0) quiesce();
      end
    end

    // ---- end of run ----
    quiesce();
    if (fail_count == 0 && pending_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

/* rtt_threshold_estimator.f */
hdl/rtte_pkg.sv
hdl/rtte_update.sv
hdl/rtt_threshold_estimator.sv
sim/rtte_checker.sv
sim/tb_rtt_threshold_estimator.sv
